/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the ARP cache resolver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ARPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpc check failed");
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpc check failed");
`else
`define ARPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/arpc_pkg.sv */
// Shared constants and controller/datapath interface types of the ARP cache resolver.
package arpc_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] RK_ANSWER = 2'd0;
  localparam logic [1:0] RK_REPLY  = 2'd1;
  localparam logic [1:0] RK_BCAST  = 2'd2;
  localparam logic [1:0] RK_FULL   = 2'd3;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic PTYPE_REQ   = 1'b0;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic load;   // take a new request and restart the scan
    logic scan;   // examine one slot
    logic exec;   // apply the update and emit the result, if any
  } arpc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } arpc_sts_t;

endpackage

/* hw/rtl/arpc_regs.sv */
// APB-style configuration registers: host IP and host MAC.
module arpc_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [31:0] host_ip_o
);

  logic [31:0] host_ip_q;
  logic [47:0] host_mac_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // paddr[3] selects the register: 0 host_ip, 8 host_mac
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_ip_q  <= '0;
      host_mac_q <= '0;
    end else if (wr_en) begin
      if (paddr[3]) begin
        host_mac_q <= pwdata[47:0];
      end else begin
        host_ip_q <= pwdata[31:0];
      end
    end
  end

  assign prdata    = paddr[3] ? {16'b0, host_mac_q} : {32'b0, host_ip_q};
  assign host_ip_o = host_ip_q;

endmodule

/* hw/rtl/arpc_ctrl.sv */
// Sequencer: accept a request, scan every slot, then apply and emit.
module arpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  arpc_pkg::arpc_sts_t sts_i,
  output arpc_pkg::arpc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts_i.scan_done) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_SCAN: cmd_o.scan = 1'b1;
      ST_EXEC: cmd_o.exec = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* hw/rtl/arpc_dp.sv */
// Datapath: request register, slot store, scan logic, update and result register.
module arpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arpc_pkg::arpc_cmd_t cmd_i,
  output arpc_pkg::arpc_sts_t sts_o,
  input  logic [31:0]         host_ip_i,
  input  logic                kind_i,
  input  logic                packet_type_i,
  input  logic [31:0]         ip_addr_i,
  input  logic [31:0]         target_ip_i,
  input  logic [47:0]         mac_addr_i,
  input  logic [15:0]         hardware_type_i,
  input  logic [7:0]          client_tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          result_kind_o,
  output logic [7:0]          reply_tag_o,
  output logic [31:0]         peer_ip_o,
  output logic [47:0]         peer_mac_o,
  output logic [3:0]          entry_index_o
);

  localparam int unsigned N = arpc_pkg::SLOT_COUNT;
  localparam int unsigned IW = arpc_pkg::IDX_W;

  // request register
  logic        kind_q, ptype_q;
  logic [31:0] ip_q, tgt_q;
  logic [47:0] mac_q;
  logic [15:0] hw_q;
  logic [7:0]  tag_q;

  // slot store
  logic [N-1:0] valid_q, resolved_q, pending_q;
  logic [31:0]  ent_ip_q  [N];
  logic [47:0]  ent_mac_q [N];
  logic [15:0]  ent_hw_q  [N];
  logic [7:0]   ent_tag_q [N];

  // scan state
  logic [IW-1:0] scan_idx_q;
  logic          match_q, free_q;
  logic [IW-1:0] match_idx_q, free_idx_q;
  logic          cap_res_q, cap_pend_q;
  logic [7:0]    cap_tag_q;
  logic [47:0]   cap_mac_q;
  logic          hit_now, free_now;

  // result register
  logic        out_valid_q;
  logic [1:0]  rk_q;
  logic [7:0]  rtag_q;
  logic [31:0] rip_q;
  logic [47:0] rmac_q;
  logic [3:0]  ridx_q;

  // exec decode
  logic          has_slot, is_new;
  logic [IW-1:0] slot;
  logic [IW+3:0] slot_ext;
  logic [3:0]    slot4;
  logic          wr_en, wr_mac, wr_res, wr_pend;
  logic [47:0]   wr_mac_val;
  logic [7:0]    wr_tag_val;
  logic          emit;
  logic [1:0]    e_kind;
  logic [7:0]    e_tag;
  logic [47:0]   e_mac;
  logic [3:0]    e_idx;

  assign sts_o.scan_done = (scan_idx_q == IW'(N - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign hit_now  = valid_q[scan_idx_q] && (ent_ip_q[scan_idx_q] == ip_q);
  assign free_now = !valid_q[scan_idx_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      ptype_q <= packet_type_i;
      ip_q    <= ip_addr_i;
      tgt_q   <= target_ip_i;
      mac_q   <= mac_addr_i;
      hw_q    <= hardware_type_i;
      tag_q   <= client_tag_i;
    end
    if (cmd_i.scan && hit_now && !match_q) begin
      match_idx_q <= scan_idx_q;
      cap_res_q   <= resolved_q[scan_idx_q];
      cap_pend_q  <= pending_q[scan_idx_q];
      cap_tag_q   <= ent_tag_q[scan_idx_q];
      cap_mac_q   <= ent_mac_q[scan_idx_q];
    end
    if (cmd_i.scan && free_now && !free_q) begin
      free_idx_q <= scan_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      match_q    <= 1'b0;
      free_q     <= 1'b0;
    end else if (cmd_i.load) begin
      scan_idx_q <= '0;
      match_q    <= 1'b0;
      free_q     <= 1'b0;
    end else if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (hit_now) match_q <= 1'b1;
      if (free_now) free_q <= 1'b1;
    end
  end

  // the first matching slot wins; a new entry goes to the lowest free slot
  assign has_slot = match_q || free_q;
  assign is_new   = !match_q;
  assign slot     = match_q ? match_idx_q : free_idx_q;
  assign slot_ext = {4'b0, slot};
  assign slot4    = slot_ext[3:0];

  always_comb begin
    wr_en      = 1'b0;
    wr_mac     = 1'b0;
    wr_res     = 1'b0;
    wr_pend    = 1'b0;
    wr_mac_val = '0;
    wr_tag_val = tag_q;
    emit       = 1'b0;
    e_kind     = arpc_pkg::RK_FULL;
    e_tag      = '0;
    e_mac      = '0;
    e_idx      = '0;
    if (kind_q == arpc_pkg::KIND_LOOKUP) begin
      emit  = 1'b1;
      e_tag = tag_q;
      if (match_q && cap_res_q) begin
        e_kind = arpc_pkg::RK_ANSWER;
        e_mac  = cap_mac_q;
        e_idx  = slot4;
      end else if (has_slot) begin
        // new pending entry, or re-arm of an unresolved one
        wr_en      = 1'b1;
        wr_mac     = is_new;
        wr_res     = 1'b0;
        wr_pend    = 1'b1;
        wr_tag_val = tag_q;
        e_kind     = arpc_pkg::RK_BCAST;
        e_mac      = arpc_pkg::MAC_BCAST;
        e_idx      = slot4;
      end
    end else begin
      wr_en      = has_slot;
      wr_mac     = 1'b1;
      wr_mac_val = mac_q;
      wr_res     = 1'b1;
      wr_pend    = (is_new || ptype_q != arpc_pkg::PTYPE_REQ) ? 1'b0 : cap_pend_q;
      wr_tag_val = is_new ? 8'd0 : cap_tag_q;
      if (ptype_q == arpc_pkg::PTYPE_REQ) begin
        if (tgt_q == host_ip_i) begin
          emit   = 1'b1;
          e_kind = arpc_pkg::RK_REPLY;
          e_mac  = mac_q;
          e_idx  = has_slot ? slot4 : 4'd0;
        end else if (!has_slot) begin
          emit = 1'b1;
        end
      end else begin
        if (!has_slot) begin
          emit = 1'b1;
        end else if (!is_new && cap_pend_q) begin
          emit   = 1'b1;
          e_kind = arpc_pkg::RK_ANSWER;
          e_tag  = cap_tag_q;
          e_mac  = mac_q;
          e_idx  = slot4;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      resolved_q <= '0;
      pending_q  <= '0;
    end else if (cmd_i.exec && wr_en) begin
      valid_q[slot]    <= 1'b1;
      resolved_q[slot] <= wr_res;
      pending_q[slot]  <= wr_pend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      ent_ip_q[slot]  <= ip_q;
      ent_hw_q[slot]  <= hw_q;
      ent_tag_q[slot] <= wr_tag_val;
      if (wr_mac) ent_mac_q[slot] <= wr_mac_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && emit) begin
      rk_q   <= e_kind;
      rtag_q <= e_tag;
      rip_q  <= ip_q;
      rmac_q <= e_mac;
      ridx_q <= e_idx;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = rk_q;
  assign reply_tag_o   = rtag_q;
  assign peer_ip_o     = rip_q;
  assign peer_mac_o    = rmac_q;
  assign entry_index_o = ridx_q;

endmodule

/* hw/rtl/arp_cache_resolver.sv */
// ARP cache resolver top level: an accepted request is scanned at one slot per cycle,
// then applied and emitted once the output register is free.
// A new request is taken only after the current one has been applied, so the slot
// scan bounds the throughput; the next request is taken while a result still waits.
// rst_ni (async, active low) clears all slot flags, host_ip and host_mac;
// the slot payloads are not cleared and are read only once written.
`include "assert_macros.svh"
module arp_cache_resolver (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tuser: [0] kind, [1] packet_type
  input  logic [1:0]   s_axis_tuser_i,
  // tdata: ip_addr[31:0], target_ip[63:32], mac_addr[111:64],
  //        hardware_type[127:112], client_tag[135:128]
  input  logic [135:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tuser: [1:0] result_kind
  output logic [1:0]   m_axis_tuser_o,
  // tdata: reply_tag[7:0], peer_ip[39:8], peer_mac[87:40], entry_index[91:88], zero pad
  output logic [95:0]  m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  arpc_pkg::arpc_cmd_t cmd;
  arpc_pkg::arpc_sts_t sts;
  logic [31:0] host_ip;
  logic [7:0]  reply_tag;
  logic [31:0] peer_ip;
  logic [47:0] peer_mac;
  logic [3:0]  entry_index;

  arpc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .host_ip_o (host_ip)
  );

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arpc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .host_ip_i       (host_ip),
    .kind_i          (s_axis_tuser_i[0]),
    .packet_type_i   (s_axis_tuser_i[1]),
    .ip_addr_i       (s_axis_tdata_i[31:0]),
    .target_ip_i     (s_axis_tdata_i[63:32]),
    .mac_addr_i      (s_axis_tdata_i[111:64]),
    .hardware_type_i (s_axis_tdata_i[127:112]),
    .client_tag_i    (s_axis_tdata_i[135:128]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .result_kind_o   (m_axis_tuser_o),
    .reply_tag_o     (reply_tag),
    .peer_ip_o       (peer_ip),
    .peer_mac_o      (peer_mac),
    .entry_index_o   (entry_index)
  );

  assign m_axis_tdata_o = {4'b0, entry_index, peer_mac, peer_ip, reply_tag};

  // an accepted request keeps the input closed while it is scanned
  `ARPC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // a result is only launched into a free output register
  `ARPC_ASSERT_NOW(a_exec_out_free, clk_i, rst_ni, cmd.exec, sts.out_free)
  // a new result only appears out of the apply step, never while idle
  `ARPC_ASSERT_NOW(a_result_from_exec, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o))

endmodule
